@@ rtl/mltc_pkg.sv @@
`default_nettype none

package mltc_pkg;

   // Character codes and field widths
   localparam int SYMBOL_W    = 8;
   localparam int LENGTH_W    = 8;
   localparam int DIGIT_W     = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SYMBOL_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [SYMBOL_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;

   // Symbol class decided by the front end
   typedef enum logic [1:0] {
      KIND_TERM,
      KIND_COLON,
      KIND_DIGIT,
      KIND_OTHER
   } kind_type;

   // One classified beat handed from front to back
   typedef struct packed {
      kind_type           kind;
      logic [DIGIT_W-1:0] digit;
   } item_type;

endpackage

`default_nettype wire

@@ rtl/mltc_front.sv @@
`default_nettype none

module mltc_front (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [mltc_pkg::SYMBOL_W-1:0]   req_symbol,
   output logic                            item_valid,
   input  wire                             item_ready,
   output mltc_pkg::item_type              item_data
);

   logic                 valid_ff, valid_in;
   mltc_pkg::item_type   item_ff, item_in;
   logic [mltc_pkg::SYMBOL_W-1:0] digit_diff;

   // Classify the incoming character
   always_comb begin
      digit_diff    = req_symbol - mltc_pkg::CHAR_ZERO;
      item_in.digit = digit_diff[mltc_pkg::DIGIT_W-1:0];
      if (req_symbol == mltc_pkg::CHAR_NUL) begin
         item_in.kind = mltc_pkg::KIND_TERM;
      end else if (req_symbol == mltc_pkg::CHAR_COLON) begin
         item_in.kind = mltc_pkg::KIND_COLON;
      end else if (req_symbol >= mltc_pkg::CHAR_ZERO &&
                   req_symbol <= mltc_pkg::CHAR_NINE) begin
         item_in.kind = mltc_pkg::KIND_DIGIT;
      end else begin
         item_in.kind = mltc_pkg::KIND_OTHER;
      end
   end

   // Take a new beat whenever the stage is empty or draining
   assign req_ready = !valid_ff || item_ready;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = item_ff;

endmodule

`default_nettype wire

@@ rtl/mltc_queue.sv @@
`default_nettype none

module mltc_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  mltc_pkg::item_type  push_data,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output mltc_pkg::item_type  pop_data
);

   localparam int PTR_W = (mltc_pkg::QUEUE_DEPTH > 1) ? $clog2(mltc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mltc_pkg::QUEUE_DEPTH + 1);

   mltc_pkg::item_type entry_ff [mltc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(mltc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mltc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mltc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Occupancy never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(mltc_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

@@ rtl/mltc_back.sv @@
`default_nettype none

module mltc_back #(
   parameter int MAX_LEN = 255
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             item_valid,
   output logic                            item_ready,
   input  mltc_pkg::item_type              item_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic                            rsp_message_ok,
   output logic [mltc_pkg::LENGTH_W-1:0]   rsp_message_length
);

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int TW = $clog2(MAX_LEN + 2);
   localparam int MW = TW + 4;

   logic          position_ok;
   logic [PW-1:0] position_ff, position_in;
   logic          too_long_ff, too_long_in;
   logic          colon_seen_ff, colon_seen_in;
   logic [PW-1:0] colon_index_ff, colon_index_in;
   logic [TW-1:0] trailer_ff, trailer_in;
   logic          digits_only_ff, digits_only_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_ok_ff, out_ok_in;
   logic [mltc_pkg::LENGTH_W-1:0] out_len_ff, out_len_in;

   logic          do_pop;
   logic [MW-1:0] trailer_next;
   logic [PW+mltc_pkg::LENGTH_W-1:0] position_wide;

   // Pop when the result register is free or being drained
   assign item_ready = !out_valid_ff || rsp_ready;
   assign do_pop     = item_valid && item_ready;

   // Times ten plus digit, by shifts
   assign trailer_next = MW'({trailer_ff, 3'b000}) + MW'({trailer_ff, 1'b0})
                       + MW'(item_data.digit);
   assign position_wide = {{mltc_pkg::LENGTH_W{1'b0}}, position_ff};
   assign position_ok   = (position_ff < PW'(MAX_LEN));

   always_comb begin
      position_in    = position_ff;
      too_long_in    = too_long_ff;
      colon_seen_in  = colon_seen_ff;
      colon_index_in = colon_index_ff;
      trailer_in     = trailer_ff;
      digits_only_in = digits_only_ff;
      out_valid_in   = out_valid_ff && !rsp_ready;
      out_ok_in      = out_ok_ff;
      out_len_in     = out_len_ff;
      if (do_pop) begin
         if (item_data.kind == mltc_pkg::KIND_TERM) begin
            // Report and clear for the next message
            out_valid_in   = 1'b1;
            out_ok_in      = colon_seen_ff && digits_only_ff && !too_long_ff &&
                             (trailer_ff == TW'(colon_index_ff));
            out_len_in     = position_wide[mltc_pkg::LENGTH_W-1:0];
            position_in    = '0;
            too_long_in    = 1'b0;
            colon_seen_in  = 1'b0;
            colon_index_in = '0;
            trailer_in     = '0;
            digits_only_in = 1'b1;
         end else if (!position_ok) begin
            too_long_in = 1'b1;
         end else begin
            position_in = position_ff + 1'b1;
            case (item_data.kind)
               mltc_pkg::KIND_COLON: begin
                  colon_seen_in  = 1'b1;
                  colon_index_in = position_ff;
                  trailer_in     = '0;
                  digits_only_in = 1'b1;
               end
               mltc_pkg::KIND_DIGIT: begin
                  if (colon_seen_ff) begin
                     trailer_in = (trailer_next > MW'(MAX_LEN)) ? TW'(MAX_LEN + 1)
                                                                : trailer_next[TW-1:0];
                  end
               end
               default: begin
                  if (colon_seen_ff) begin
                     digits_only_in = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         too_long_ff    <= 1'b0;
         colon_seen_ff  <= 1'b0;
         colon_index_ff <= '0;
         trailer_ff     <= '0;
         digits_only_ff <= 1'b1;
         out_valid_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         too_long_ff    <= too_long_in;
         colon_seen_ff  <= colon_seen_in;
         colon_index_ff <= colon_index_in;
         trailer_ff     <= trailer_in;
         digits_only_ff <= digits_only_in;
         out_valid_ff   <= out_valid_in;
      end
      out_ok_ff  <= out_ok_in;
      out_len_ff <= out_len_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_message_ok     = out_ok_ff;
   assign rsp_message_length = out_len_ff;

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      position_ff <= PW'(MAX_LEN))
      else $error("position past limit");

   a_trailer_bound: assert property (@(posedge clock) disable iff (reset)
      trailer_ff <= TW'(MAX_LEN + 1))
      else $error("trailer value past saturation");

   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      (do_pop && item_data.kind == mltc_pkg::KIND_TERM) |=>
         (position_ff == '0 && !colon_seen_ff && !too_long_ff && rsp_valid))
      else $error("message state not cleared after terminator");

   a_overflow_at_limit: assert property (@(posedge clock) disable iff (reset)
      too_long_ff |-> position_ff == PW'(MAX_LEN))
      else $error("overlong flag without full count");

endmodule

`default_nettype wire

@@ rtl/message_length_trailer_check.sv @@
// A terminator's result passes the front register, queue and result register to rsp_valid.
// Throughput: one character per cycle unless stalled; the front register, the two-entry
// queue and the result register let each side stall independently.
// Per-character work is one register update in the back end (times ten plus digit).
// Reset (synchronous, active high) empties the pipeline and clears message state.
`default_nettype none

module message_length_trailer_check #(
   parameter int MAX_LEN = 255
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [mltc_pkg::SYMBOL_W-1:0]  req_symbol,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_message_ok,
   output logic [mltc_pkg::LENGTH_W-1:0]  rsp_message_length
);

   logic               front_valid, front_ready;
   mltc_pkg::item_type front_data;
   logic               queue_valid, queue_ready;
   mltc_pkg::item_type queue_data;

   // Classify incoming characters
   mltc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_symbol (req_symbol),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item_data  (front_data)
   );

   // Decouple front and back
   mltc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_data)
   );

   // Track message state and report at the terminator
   mltc_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (queue_valid),
      .item_ready         (queue_ready),
      .item_data          (queue_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_message_ok     (rsp_message_ok),
      .rsp_message_length (rsp_message_length)
   );

endmodule

`default_nettype wire
